### rtl/core/pati_pkg.sv
// ----------------------------------------------------------------------------
// pati_pkg
// Shared types and constants for the two-axis trajectory interpolator.
// ----------------------------------------------------------------------------
package pati_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int TIME_W          = 48;
  localparam int POS_W           = 48;
  localparam int VAL_W           = 32;
  localparam int CFG_W           = 48;
  localparam int CFG_IDX_W       = 3;
  localparam int SEG_OUT_W       = 6;
  localparam logic [31:0] TICK_STEP_RST = 32'd655;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_APPEND_X = 2'd1,
    CMD_APPEND_Y = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_STEP = 3'd0,
    REG_START_X   = 3'd1,
    REG_START_Y   = 3'd2,
    REG_START_VX  = 3'd3,
    REG_START_VY  = 3'd4
  } reg_t;

  // start record of one segment
  typedef struct packed {
    logic        [TIME_W-1:0] tm;
    logic signed [VAL_W-1:0]  vel;
    logic signed [POS_W-1:0]  pos;
  } rec_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic axis;
    logic time_step;
    logic rd_next;
    logic cmp;
    logic rd_cur;
    logic ld_tick;
    logic rd_app;
    logic ld_app;
    logic refuse;
    logic mul_start;
    logic mul_step;
    logic fin1;
    logic fin2;
    logic fin3;
    logic wr_app;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic mul_last;
  } sts_t;

endpackage

### rtl/core/pati_ctrl.sv
// ----------------------------------------------------------------------------
// pati_ctrl
// Sequencer: walks each tick and unrefused append via table reads, multiply
// steps and result stages of the datapath; a clear goes straight to done.
// ----------------------------------------------------------------------------
module pati_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pati_pkg::cmd_t     command,
  input  pati_pkg::sts_t     sts,
  output pati_pkg::ctl_t     ctl,
  output logic               busy,
  output logic               done
);
  import pati_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_TSTEP = 14'h0002,
    S_RNXT  = 14'h0004,
    S_CMP   = 14'h0008,
    S_RCUR  = 14'h0010,
    S_TLOAD = 14'h0020,
    S_ARD   = 14'h0040,
    S_ALOAD = 14'h0080,
    S_MUL   = 14'h0100,
    S_FIN1  = 14'h0200,
    S_FIN2  = 14'h0400,
    S_FIN3  = 14'h0800,
    S_AWR   = 14'h1000,
    S_DONE  = 14'h2000
  } state_t;

  state_t state, state_next;
  logic   axis, axis_next;
  logic   is_tick, is_tick_next;

  always_comb begin
    state_next   = state;
    axis_next    = axis;
    is_tick_next = is_tick;
    ctl          = '0;
    ctl.axis     = axis;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch    = 1'b1;
          is_tick_next = (command == CMD_TICK);
          case (command)
            CMD_CLEAR: begin
              ctl.clear  = 1'b1;
              state_next = S_DONE;
            end
            CMD_APPEND_X: begin
              axis_next  = 1'b0;
              state_next = S_ARD;
            end
            CMD_APPEND_Y: begin
              axis_next  = 1'b1;
              state_next = S_ARD;
            end
            default: begin
              axis_next  = 1'b0;
              state_next = S_TSTEP;
            end
          endcase
        end
      end
      S_TSTEP: begin
        ctl.time_step = 1'b1;
        state_next    = S_RNXT;
      end
      S_RNXT: begin
        ctl.rd_next = 1'b1;
        state_next  = S_CMP;
      end
      S_CMP: begin
        ctl.cmp    = 1'b1;
        state_next = S_RCUR;
      end
      S_RCUR: begin
        ctl.rd_cur = 1'b1;
        state_next = S_TLOAD;
      end
      S_TLOAD: begin
        ctl.ld_tick   = 1'b1;
        ctl.mul_start = 1'b1;
        state_next    = S_MUL;
      end
      S_ARD: begin
        ctl.rd_app = 1'b1;
        ctl.refuse = sts.full;
        state_next = sts.full ? S_DONE : S_ALOAD;
      end
      S_ALOAD: begin
        ctl.ld_app    = 1'b1;
        ctl.mul_start = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        if (sts.mul_last) state_next = S_FIN1;
      end
      S_FIN1: begin
        ctl.fin1   = 1'b1;
        state_next = S_FIN2;
      end
      S_FIN2: begin
        ctl.fin2   = 1'b1;
        state_next = S_FIN3;
      end
      S_FIN3: begin
        ctl.fin3 = 1'b1;
        if (!is_tick) begin
          state_next = S_AWR;
        end else if (!axis) begin
          axis_next  = 1'b1;
          state_next = S_RNXT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_AWR: begin
        ctl.wr_app = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      axis    <= 1'b0;
      is_tick <= 1'b0;
    end else begin
      state   <= state_next;
      axis    <= axis_next;
      is_tick <= is_tick_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

### rtl/core/pati_dp.sv
// ----------------------------------------------------------------------------
// pati_dp
// Datapath: configuration, segment tables, time and index registers, a
// shared 32x32 multiplier with accumulators, and the result stages.
// ----------------------------------------------------------------------------
module pati_dp #(
  parameter int MAX_SEGMENTS = pati_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pati_pkg::ctl_t                       ctl,
  output pati_pkg::sts_t                       sts,
  input  logic [1:0]                           command,
  input  logic signed [pati_pkg::VAL_W-1:0]    acceleration,
  input  logic [pati_pkg::VAL_W-1:0]           duration,
  input  logic                                 cfg_we,
  input  logic [pati_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pati_pkg::CFG_W-1:0]           cfg_wdata,
  output logic signed [pati_pkg::POS_W-1:0]    pos_x,
  output logic signed [pati_pkg::POS_W-1:0]    pos_y,
  output logic [pati_pkg::SEG_OUT_W-1:0]       current_seg_x,
  output logic [pati_pkg::SEG_OUT_W-1:0]       current_seg_y,
  output logic                                 status
);
  import pati_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int TA_SH = 2 * FRAC_BITS + 1;
  localparam logic signed [127:0] P_MAX = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] P_MIN = -128'sh8000_0000_0000;
  localparam logic signed [65:0]  V_MAX = 66'sh7FFF_FFFF;
  localparam logic signed [65:0]  V_MIN = -66'sh8000_0000;
  localparam logic [TIME_W-1:0]   T_MAX = '1;

  // configuration
  logic        [31:0]       tick_step;
  logic signed [POS_W-1:0]  start_x, start_y;
  logic signed [VAL_W-1:0]  start_vx, start_vy;

  // control state
  logic [TIME_W-1:0] elapsed;
  logic [IW-1:0]     idx_x, idx_y, cnt_x, cnt_y;

  // captured request
  cmd_t                    cmd_r;
  logic signed [VAL_W-1:0] acc_in;
  logic [VAL_W-1:0]        dur_in;

  // segment tables, entry e >= 1 lives at address e-1; entry zero is the start regs
  rec_t                    rec_x [MAX_SEGMENTS];
  rec_t                    rec_y [MAX_SEGMENTS];
  logic signed [VAL_W-1:0] acc_x [MAX_SEGMENTS];
  logic signed [VAL_W-1:0] acc_y [MAX_SEGMENTS];
  rec_t                    rec_rd;
  logic signed [VAL_W-1:0] acc_rd;
  logic                    rd_zero;

  // operands
  logic signed [VAL_W-1:0] op_a, op_v;
  logic signed [POS_W-1:0] op_p;
  logic [TIME_W-1:0]       op_dt, t_next;

  // multiplier and accumulators
  logic [3:0]   mul_k, pk;
  logic [63:0]  prod;
  logic [95:0]  dt2;
  logic [127:0] ta;
  logic [79:0]  tv;
  logic [63:0]  dv;
  logic signed [127:0] ta_s, s1;
  logic signed [80:0]  tv_s;
  logic signed [64:0]  dv_s;
  logic signed [VAL_W-1:0] vel_new;
  logic signed [POS_W-1:0] res_pos;
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic                    status_r;

  // combinational helpers
  logic [IW-1:0]           cur_idx, cur_cnt, rd_e;
  logic [AW-1:0]           raddr, waddr, aaddr;
  logic                    rd_en;
  rec_t                    rec_now;
  logic [31:0]             am, mv, ma, mb;
  logic [TIME_W:0]         esum, tsum;
  logic [TIME_W-1:0]       esat, tsat, dt_tick;
  logic signed [65:0]      vsum;
  logic signed [VAL_W-1:0] vsat;
  logic signed [127:0]     psum;
  logic signed [POS_W-1:0] psat;

  always_comb begin
    cur_idx = ctl.axis ? idx_y : idx_x;
    cur_cnt = ctl.axis ? cnt_y : cnt_x;
    rd_e    = ctl.rd_next ? IW'(cur_idx + 1'b1) : (ctl.rd_app ? cur_cnt : cur_idx);
    raddr   = AW'(rd_e - 1'b1);
    aaddr   = AW'(cur_idx);
    waddr   = AW'(cur_cnt);
    rd_en   = ctl.rd_next | ctl.rd_cur | ctl.rd_app;

    if (rd_zero) begin
      rec_now.tm  = '0;
      rec_now.vel = ctl.axis ? start_vy : start_vx;
      rec_now.pos = ctl.axis ? start_y : start_x;
    end else begin
      rec_now = rec_rd;
    end

    esum    = {1'b0, elapsed} + (TIME_W+1)'(tick_step);
    esat    = esum[TIME_W] ? T_MAX : esum[TIME_W-1:0];
    tsum    = {1'b0, rec_now.tm} + (TIME_W+1)'(dur_in);
    tsat    = tsum[TIME_W] ? T_MAX : tsum[TIME_W-1:0];
    dt_tick = (elapsed > rec_now.tm) ? (elapsed - rec_now.tm) : '0;

    am = op_a[VAL_W-1] ? (~op_a + 1'b1) : op_a;
    mv = op_v[VAL_W-1] ? (~op_v + 1'b1) : op_v;

    // operand schedule: dt^2, then v*dt and a*d, then dt^2*a once dt^2 has settled
    case (mul_k)
      4'd0:    begin ma = op_dt[31:0];          mb = op_dt[31:0];          end
      4'd1:    begin ma = op_dt[31:0];          mb = 32'(op_dt[47:32]);    end
      4'd2:    begin ma = op_dt[31:0];          mb = 32'(op_dt[47:32]);    end
      4'd3:    begin ma = 32'(op_dt[47:32]);    mb = 32'(op_dt[47:32]);    end
      4'd4:    begin ma = mv;                   mb = op_dt[31:0];          end
      4'd5:    begin ma = mv;                   mb = 32'(op_dt[47:32]);    end
      4'd6:    begin ma = am;                   mb = op_dt[31:0];          end
      4'd7:    begin ma = dt2[31:0];            mb = am;                   end
      4'd8:    begin ma = dt2[63:32];           mb = am;                   end
      4'd9:    begin ma = dt2[95:64];           mb = am;                   end
      default: begin ma = '0;                   mb = '0;                   end
    endcase

    vsum = 66'(dv_s >>> FRAC_BITS) + 66'(op_v);
    if (vsum > V_MAX)      vsat = {1'b0, {(VAL_W-1){1'b1}}};
    else if (vsum < V_MIN) vsat = {1'b1, {(VAL_W-1){1'b0}}};
    else                   vsat = vsum[VAL_W-1:0];

    psum = s1 + 128'(op_p);
    if (psum > P_MAX)      psat = {1'b0, {(POS_W-1){1'b1}}};
    else if (psum < P_MIN) psat = {1'b1, {(POS_W-1){1'b0}}};
    else                   psat = psum[POS_W-1:0];
  end

  // configuration and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RST;
      start_x   <= '0;
      start_y   <= '0;
      start_vx  <= '0;
      start_vy  <= '0;
      elapsed   <= '0;
      idx_x     <= '0;
      idx_y     <= '0;
      cnt_x     <= '0;
      cnt_y     <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_t'(cfg_addr))
          REG_TICK_STEP: tick_step <= cfg_wdata[31:0];
          REG_START_X:   start_x   <= cfg_wdata[POS_W-1:0];
          REG_START_Y:   start_y   <= cfg_wdata[POS_W-1:0];
          REG_START_VX:  start_vx  <= cfg_wdata[VAL_W-1:0];
          REG_START_VY:  start_vy  <= cfg_wdata[VAL_W-1:0];
          default: ;
        endcase
      end
      if (ctl.clear) begin
        elapsed <= '0;
        idx_x   <= '0;
        idx_y   <= '0;
        cnt_x   <= '0;
        cnt_y   <= '0;
      end
      if (ctl.time_step) elapsed <= esat;
      // move on at most one segment when time has passed the segment end
      if (ctl.cmp && (cur_idx < cur_cnt) && (elapsed > rec_rd.tm)) begin
        if (ctl.axis) idx_y <= idx_y + 1'b1;
        else          idx_x <= idx_x + 1'b1;
      end
      if (ctl.wr_app) begin
        if (ctl.axis) cnt_y <= cnt_y + 1'b1;
        else          cnt_x <= cnt_x + 1'b1;
      end
    end
  end

  // segment tables
  always_ff @(posedge clk) begin
    if (ctl.wr_app) begin
      if (ctl.axis) begin
        rec_y[waddr] <= '{tm: t_next, vel: vel_new, pos: res_pos};
        acc_y[waddr] <= op_a;
      end else begin
        rec_x[waddr] <= '{tm: t_next, vel: vel_new, pos: res_pos};
        acc_x[waddr] <= op_a;
      end
    end
    if (rd_en) begin
      rec_rd  <= ctl.axis ? rec_y[raddr] : rec_x[raddr];
      acc_rd  <= ctl.axis ? acc_y[aaddr] : acc_x[aaddr];
      rd_zero <= (rd_e == '0);
    end
  end

  // request capture, operands, multiply-accumulate and result stages
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r    <= cmd_t'(command);
      acc_in   <= acceleration;
      dur_in   <= duration;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      status_r <= 1'b0;
    end
    if (ctl.refuse) status_r <= 1'b1;
    if (ctl.ld_tick) begin
      op_a  <= (cur_idx < cur_cnt) ? acc_rd : '0;
      op_v  <= rec_now.vel;
      op_p  <= rec_now.pos;
      op_dt <= dt_tick;
    end
    if (ctl.ld_app) begin
      op_a   <= acc_in;
      op_v   <= rec_now.vel;
      op_p   <= rec_now.pos;
      op_dt  <= TIME_W'(dur_in);
      t_next <= tsat;
    end
    if (ctl.mul_start) begin
      mul_k <= '0;
      pk    <= '0;
      dt2   <= '0;
      ta    <= '0;
      tv    <= '0;
      dv    <= '0;
    end else if (ctl.mul_step) begin
      mul_k <= mul_k + 1'b1;
      prod  <= ma * mb;
      pk    <= mul_k;
      if (mul_k != '0) begin
        case (pk)
          4'd0:    dt2 <= dt2 + 96'(prod);
          4'd1:    dt2 <= dt2 + (96'(prod) << 32);
          4'd2:    dt2 <= dt2 + (96'(prod) << 32);
          4'd3:    dt2 <= dt2 + (96'(prod) << 64);
          4'd4:    tv  <= tv + 80'(prod);
          4'd5:    tv  <= tv + (80'(prod) << 32);
          4'd6:    dv  <= prod;
          4'd7:    ta  <= ta + 128'(prod);
          4'd8:    ta  <= ta + (128'(prod) << 32);
          4'd9:    ta  <= ta + (128'(prod) << 64);
          default: ;
        endcase
      end
    end
    if (ctl.fin1) begin
      ta_s <= op_a[VAL_W-1] ? -$signed(ta) : $signed(ta);
      tv_s <= op_v[VAL_W-1] ? -$signed({1'b0, tv}) : $signed({1'b0, tv});
      dv_s <= op_a[VAL_W-1] ? -$signed({1'b0, dv}) : $signed({1'b0, dv});
    end
    if (ctl.fin2) begin
      s1      <= (ta_s >>> TA_SH) + 128'(tv_s >>> FRAC_BITS);
      vel_new <= vsat;
    end
    if (ctl.fin3) begin
      res_pos <= psat;
      if (cmd_r == CMD_TICK) begin
        if (ctl.axis) pos_y_r <= psat;
        else          pos_x_r <= psat;
      end
    end
  end

  assign sts.full     = (cur_cnt >= IW'(MAX_SEGMENTS));
  assign sts.mul_last = (mul_k == 4'd10);

  assign pos_x         = pos_x_r;
  assign pos_y         = pos_y_r;
  assign current_seg_x = SEG_OUT_W'(idx_x);
  assign current_seg_y = SEG_OUT_W'(idx_y);
  assign status        = status_r;

endmodule

### rtl/core/piecewise_accel_trajectory_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_accel_trajectory_interpolator
// Two-axis profile generator over tables of constant-acceleration segments.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         command, acceleration, duration
//  result    done (1 cycle)       pos_x, pos_y, current_seg_x/y, status
//  config    cfg_we               cfg_addr, cfg_wdata
//
//  a new request is taken only once busy has fallen. A clear goes straight to done; an
//  append reads the table and evaluates one position, or is refused when the table is
//  full; a tick evaluates one position per axis in turn. The single shared 32x32
//  multiplier forms 10 products per position evaluation, once per axis in a tick.
//  rst (synchronous) clears time, indices and counts; no clearing pass.
//  busy stays high through the done cycle; results cannot be held off.
module piecewise_accel_trajectory_interpolator #(
  parameter int MAX_SEGMENTS = pati_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           command,
  input  logic signed [pati_pkg::VAL_W-1:0]    acceleration,
  input  logic [pati_pkg::VAL_W-1:0]           duration,
  output logic                                 done,
  output logic signed [pati_pkg::POS_W-1:0]    pos_x,
  output logic signed [pati_pkg::POS_W-1:0]    pos_y,
  output logic [pati_pkg::SEG_OUT_W-1:0]       current_seg_x,
  output logic [pati_pkg::SEG_OUT_W-1:0]       current_seg_y,
  output logic                                 status,
  input  logic                                 cfg_we,
  input  logic [pati_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pati_pkg::CFG_W-1:0]           cfg_wdata
);
  import pati_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pati_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (cmd_t'(command)),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy),
    .done    (done)
  );

  pati_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .command       (command),
    .acceleration  (acceleration),
    .duration      (duration),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .current_seg_x (current_seg_x),
    .current_seg_y (current_seg_y),
    .status        (status)
  );

`ifndef NO_ASSERTIONS
  // an accepted request keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // one strobe per request
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a refused append reports no position
  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (pos_x == '0 && pos_y == '0))
    else $error("refused append with non-zero position");
`endif

endmodule
